/* rtl/oui_vendor_prefix_lookup_defines.svh */
// Assertion macros shared by the vendor prefix lookup RTL.
`ifndef OUI_VENDOR_PREFIX_LOOKUP_DEFINES_SVH
`define OUI_VENDOR_PREFIX_LOOKUP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define OVPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define OVPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ovpl_pkg.sv */
// Shared types and constants of the vendor prefix lookup block.
package ovpl_pkg;

  localparam int MAC_W               = 48;
  localparam int KEY_L_W             = 24;
  localparam int KEY_M_W             = 28;
  localparam int KEY_S_W             = 36;
  localparam int TAG_W               = 16;
  localparam int DEF_TABLE_ENTRIES   = 64;
  localparam int DEF_VENDOR_BITS     = 16;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD    = 1'b1;

  typedef enum logic [2:0] {
    ST_MISS  = 3'd0,
    ST_HIT   = 3'd1,
    ST_ADDED = 3'd2,
    ST_CID   = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_L   = 2'd0,
    CLS_M   = 2'd1,
    CLS_S   = 2'd2,
    CLS_CID = 2'd3
  } class_t;

  // Commands from the sequencer to one table.
  typedef struct packed {
    logic start;
    logic add;
  } tbl_ctrl_t;

  // Status of one table back to the sequencer.
  typedef struct packed {
    logic full;
    logic done;
    logic hit;
  } tbl_stat_t;

endpackage

/* rtl/ovpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ovpl_ram import ovpl_pkg::*; #(
  parameter int WIDTH = 40,
  parameter int DEPTH = DEF_TABLE_ENTRIES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ovpl_table.sv */
// One prefix table: entry memory, fill count and linear first-match scanner.
module ovpl_table import ovpl_pkg::*; #(
  parameter int KEY_W         = KEY_L_W,
  parameter int VENDOR_BITS   = DEF_VENDOR_BITS,
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbl_ctrl_t              ctrl,
  input  logic [KEY_W-1:0]       add_key,
  input  logic [VENDOR_BITS-1:0] add_tag,
  input  logic [KEY_W-1:0]       find_key,
  output tbl_stat_t              stat,
  output logic [VENDOR_BITS-1:0] found_tag
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int DATA_W = KEY_W + VENDOR_BITS;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic              pend;
  logic              active;
  logic              done;
  logic              hit;
  logic [DATA_W-1:0] rdata;
  logic              full;
  logic              wr_en;
  logic              match;
  logic              last;
  logic              rd_en;

  assign full  = (count == CNT_W'(TABLE_ENTRIES));
  assign wr_en = ctrl.add && !full;
  assign match = pend && (rdata[DATA_W-1 -: KEY_W] == find_key);
  assign last  = (ptr == count);
  assign rd_en = active && !match && !last;

  ovpl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata ({add_key, add_tag}),
    .re    (rd_en),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ptr    <= '0;
      pend   <= 1'b0;
      active <= 1'b0;
      done   <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (ctrl.start) begin
        ptr    <= '0;
        pend   <= 1'b0;
        active <= 1'b1;
        done   <= 1'b0;
        hit    <= 1'b0;
      end else if (active) begin
        if (match) begin
          // first match wins: stop the scan
          hit    <= 1'b1;
          done   <= 1'b1;
          active <= 1'b0;
          pend   <= 1'b0;
        end else if (last && !pend) begin
          done   <= 1'b1;
          active <= 1'b0;
        end else begin
          pend <= rd_en;
          if (rd_en) begin
            ptr <= ptr + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && match) begin
      found_tag <= rdata[VENDOR_BITS-1:0];
    end
  end

  assign stat.full = full;
  assign stat.done = done;
  assign stat.hit  = hit;

endmodule

/* rtl/oui_vendor_prefix_lookup.sv */
// Top level of the MAC vendor prefix lookup: request sequencer and three prefix tables.
// MAC vendor prefix lookup. Three tables hold MA-L (24-bit), MA-M (28-bit) and MA-S
// (36-bit) prefixes of a 48-bit MAC, each entry stored with a vendor tag. An add word
// masks the MAC to the prefix of its class and appends the entry; a CID class is
// rejected and a full table reports full without storing. A lookup word scans all
// three tables at once and returns the MA-S match, else MA-M, else MA-L, taking the
// earliest entry within a table. An add's result word is registered when the add is
// taken and offered in the next cycle. A lookup reads each table through the single
// read port of its memory, one entry per cycle, up to the table's fill count or its
// first match; the result word is registered once all three tables are done. One request
// is in flight at a time; a new word is taken in the same cycle the waiting result is
// taken. dirty reports whether any add has succeeded since reset. No clearing pass
// is needed after reset: the fill counts bound every read.
`include "oui_vendor_prefix_lookup_defines.svh"

module oui_vendor_prefix_lookup import ovpl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int VENDOR_BITS   = DEF_VENDOR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             req_type,
  input  logic [MAC_W-1:0] mac_addr,
  input  logic [1:0]       block_class,
  input  logic [TAG_W-1:0] vendor_tag,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [2:0]       status,
  output logic [1:0]       match_class,
  output logic [TAG_W-1:0] found_vendor,
  output logic             dirty
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic                   is_add;
  logic [MAC_W-1:0]       mac_q;
  logic [VENDOR_BITS-1:0] tag_in;
  logic                   all_done;
  logic                   changed;
  status_t                add_status;
  logic                   add_ok;

  tbl_ctrl_t ctrl_l, ctrl_m, ctrl_s;
  tbl_stat_t stat_l, stat_m, stat_s;
  logic [VENDOR_BITS-1:0] tag_l, tag_m, tag_s;

  // result register
  status_t          rsp_status;
  class_t           rsp_class;
  logic [TAG_W-1:0] rsp_vendor;
  logic             rsp_dirty;

  // take a word when idle, or when the waiting result leaves this cycle
  assign req_stall = !((state == S_IDLE) || ((state == S_OUT) && !rsp_stall));
  assign accept    = req_valid && !req_stall;
  assign is_add    = (req_type == REQ_ADD);
  assign tag_in    = VENDOR_BITS'(vendor_tag);
  assign all_done  = stat_l.done && stat_m.done && stat_s.done;

  assign ctrl_l.start = accept && !is_add;
  assign ctrl_m.start = accept && !is_add;
  assign ctrl_s.start = accept && !is_add;
  assign ctrl_l.add   = accept && is_add && (block_class == CLS_L);
  assign ctrl_m.add   = accept && is_add && (block_class == CLS_M);
  assign ctrl_s.add   = accept && is_add && (block_class == CLS_S);

  ovpl_table #(
    .KEY_W         (KEY_L_W),
    .VENDOR_BITS   (VENDOR_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_tbl_l (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_l),
    .add_key   (mac_addr[MAC_W-1 -: KEY_L_W]),
    .add_tag   (tag_in),
    .find_key  (mac_q[MAC_W-1 -: KEY_L_W]),
    .stat      (stat_l),
    .found_tag (tag_l)
  );

  ovpl_table #(
    .KEY_W         (KEY_M_W),
    .VENDOR_BITS   (VENDOR_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_tbl_m (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_m),
    .add_key   (mac_addr[MAC_W-1 -: KEY_M_W]),
    .add_tag   (tag_in),
    .find_key  (mac_q[MAC_W-1 -: KEY_M_W]),
    .stat      (stat_m),
    .found_tag (tag_m)
  );

  ovpl_table #(
    .KEY_W         (KEY_S_W),
    .VENDOR_BITS   (VENDOR_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_tbl_s (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_s),
    .add_key   (mac_addr[MAC_W-1 -: KEY_S_W]),
    .add_tag   (tag_in),
    .find_key  (mac_q[MAC_W-1 -: KEY_S_W]),
    .stat      (stat_s),
    .found_tag (tag_s)
  );

  // outcome of an add word, known in its accept cycle
  always_comb begin
    add_status = ST_CID;
    add_ok     = 1'b0;
    case (block_class)
      CLS_L: begin
        add_status = stat_l.full ? ST_FULL : ST_ADDED;
        add_ok     = !stat_l.full;
      end
      CLS_M: begin
        add_status = stat_m.full ? ST_FULL : ST_ADDED;
        add_ok     = !stat_m.full;
      end
      CLS_S: begin
        add_status = stat_s.full ? ST_FULL : ST_ADDED;
        add_ok     = !stat_s.full;
      end
      default: begin
        add_status = ST_CID;
        add_ok     = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_add ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (all_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (accept) begin
          state_next = is_add ? S_OUT : S_SCAN;
        end else if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      changed <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_add && add_ok) begin
        changed <= 1'b1;
      end
    end
  end

  // hold the MAC for the scan and load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      mac_q <= mac_addr;
    end
    if (accept && is_add) begin
      rsp_status <= add_status;
      rsp_class  <= CLS_L;
      rsp_vendor <= '0;
      rsp_dirty  <= changed || add_ok;
    end else if ((state == S_SCAN) && all_done) begin
      rsp_dirty <= changed;
      if (stat_s.hit) begin
        rsp_status <= ST_HIT;
        rsp_class  <= CLS_S;
        rsp_vendor <= TAG_W'(tag_s);
      end else if (stat_m.hit) begin
        rsp_status <= ST_HIT;
        rsp_class  <= CLS_M;
        rsp_vendor <= TAG_W'(tag_m);
      end else if (stat_l.hit) begin
        rsp_status <= ST_HIT;
        rsp_class  <= CLS_L;
        rsp_vendor <= TAG_W'(tag_l);
      end else begin
        rsp_status <= ST_MISS;
        rsp_class  <= CLS_L;
        rsp_vendor <= '0;
      end
    end
  end

  assign rsp_valid    = (state == S_OUT);
  assign status       = rsp_status;
  assign match_class  = rsp_class;
  assign found_vendor = rsp_vendor;
  assign dirty        = rsp_dirty;

  `OVPL_ASSERT_NEXT(a_scan_to_out, (state == S_SCAN) && all_done, state == S_OUT, "scan end did not offer a result")
  `OVPL_ASSERT_NEXT(a_changed_sticky, changed, changed, "change flag dropped")
  `OVPL_ASSERT_NEXT(a_cid_rejected, accept && is_add && (block_class == CLS_CID), rsp_valid && (rsp_status == ST_CID), "CID add not rejected")
  `OVPL_ASSERT_NOW(a_no_take_in_scan, state == S_SCAN, req_stall, "word taken during a scan")

endmodule

/* tb/sv/tb_oui_vendor_prefix_lookup.sv */
// Testbench for the MAC vendor prefix lookup: directed, random and back-pressure traffic.
`timescale 1ns / 1ps

module tb_oui_vendor_prefix_lookup;
  import ovpl_pkg::*;

  localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  // Cycles with no word moving on either side before the run is declared hung. The
  // slowest legal gap is a full three-table scan plus a long response hold-off.
  localparam int HANG_LIMIT    = 4000;
  // Cycles to keep watching after the last result, longer than one full scan.
  localparam int TAIL_CYCLES   = 100;
  localparam int HOLD_OFF      = 200;

  typedef struct {
    status_t              status;
    class_t               mclass;
    logic [TAG_W-1:0]     vendor;
    logic                 dirty;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic             req_type = REQ_LOOKUP;
  logic [MAC_W-1:0] mac_addr = '0;
  logic [1:0]       block_class = CLS_L;
  logic [TAG_W-1:0] vendor_tag = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [2:0]       status;
  logic [1:0]       match_class;
  logic [TAG_W-1:0] found_vendor;
  logic             dirty;

  // Predictor state: one prefix table per block class, in add order.
  logic [MAC_W-1:0] prefix_mem [3][TABLE_ENTRIES];
  logic [TAG_W-1:0] tag_mem    [3][TABLE_ENTRIES];
  int               fill [3] = '{0, 0, 0};
  logic             table_dirty = 1'b0;

  lookup_result_t   results_due [$];
  logic [MAC_W-1:0] known_macs [$];
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               hold_request = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;

  oui_vendor_prefix_lookup u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .mac_addr     (mac_addr),
    .block_class  (block_class),
    .vendor_tag   (vendor_tag),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .match_class  (match_class),
    .found_vendor (found_vendor),
    .dirty        (dirty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mask that keeps the prefix of one block class.
  function automatic logic [MAC_W-1:0] prefix_mask(input int cls);
    case (cls)
      CLS_L:   return {MAC_W{1'b1}} << (MAC_W - KEY_L_W);
      CLS_M:   return {MAC_W{1'b1}} << (MAC_W - KEY_M_W);
      default: return {MAC_W{1'b1}} << (MAC_W - KEY_S_W);
    endcase
  endfunction

  // Work out the result of one word and advance the predictor's tables.
  function automatic lookup_result_t predict_lookup_result(input logic w_type,
      input logic [MAC_W-1:0] w_mac, input logic [1:0] w_cls, input logic [TAG_W-1:0] w_tag);
    lookup_result_t   res;
    logic [MAC_W-1:0] key;
    logic [TAG_W-1:0] kept_tag;
    bit               hit;
    res.status = ST_MISS;
    res.mclass = CLS_L;
    res.vendor = '0;
    kept_tag = w_tag & TAG_W'((64'd1 << DEF_VENDOR_BITS) - 1);
    hit = 1'b0;
    if (w_type == REQ_ADD) begin
      if (w_cls == CLS_CID) begin
        res.status = ST_CID;
      end else if (fill[w_cls] >= TABLE_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        // Append even when the prefix is already present; the first copy wins later.
        prefix_mem[w_cls][fill[w_cls]] = w_mac & prefix_mask(w_cls);
        tag_mem[w_cls][fill[w_cls]] = kept_tag;
        fill[w_cls]++;
        table_dirty = 1'b1;
        res.status = ST_ADDED;
      end
    end else begin
      // Most specific class first, earliest entry first; the class field is ignored.
      for (int t = int'(CLS_S); t >= 0 && !hit; t--) begin
        key = w_mac & prefix_mask(t);
        for (int i = 0; i < fill[t] && !hit; i++) begin
          if (prefix_mem[t][i] == key) begin
            hit = 1'b1;
            res.status = ST_HIT;
            res.mclass = class_t'(t);
            res.vendor = tag_mem[t][i];
          end
        end
      end
    end
    res.dirty = table_dirty;
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // Take a MAC seen before and scramble the bits below a random prefix length, so that
  // lookups hit, nest across classes or just miss.
  function automatic logic [MAC_W-1:0] mac_near_known();
    logic [MAC_W-1:0] base;
    logic [MAC_W-1:0] keep;
    if (known_macs.size() == 0) return random_mac();
    base = known_macs[$urandom_range(known_macs.size() - 1)];
    case ($urandom_range(4))
      0:       keep = {MAC_W{1'b1}} << (MAC_W - KEY_L_W);
      1:       keep = {MAC_W{1'b1}} << (MAC_W - KEY_M_W);
      2:       keep = {MAC_W{1'b1}} << (MAC_W - KEY_S_W);
      3:       keep = {MAC_W{1'b1}} << (MAC_W - 20);
      default: keep = {MAC_W{1'b1}};
    endcase
    return (base & keep) | (random_mac() & ~keep);
  endfunction

  // Offer one word, hold it until taken, then record its expected result.
  task automatic send_word(input logic w_type, input logic [MAC_W-1:0] w_mac,
      input logic [1:0] w_cls, input logic [TAG_W-1:0] w_tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= w_type;
    mac_addr    <= w_mac;
    block_class <= w_cls;
    vendor_tag  <= w_tag;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    results_due.insert(results_due.size(),
                       predict_lookup_result(w_type, w_mac, w_cls, w_tag));
    if (w_type == REQ_ADD) known_macs.insert(known_macs.size(), w_mac);
  endtask

  task automatic send_random_word();
    int         pick;
    logic [1:0] cls;
    pick = $urandom_range(99);
    if (pick < 40) begin
      pick = $urandom_range(9);
      cls = (pick < 3) ? CLS_L : (pick < 6) ? CLS_M : (pick < 9) ? CLS_S : CLS_CID;
      send_word(REQ_ADD, $urandom_range(1) ? mac_near_known() : random_mac(), cls,
                TAG_W'($urandom));
    end else begin
      send_word(REQ_LOOKUP, ($urandom_range(3) != 0) ? mac_near_known() : random_mac(),
                2'($urandom), TAG_W'($urandom));
    end
  endtask

  // Drop the request side, then wait until every expected result is back.
  task automatic wait_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Empty tables, every class, CID reject, class nesting, duplicates, field extremes.
  task automatic test_directed_cases();
    send_word(REQ_LOOKUP, '0, CLS_L, '0);
    send_word(REQ_ADD, {MAC_W{1'b1}}, CLS_CID, {TAG_W{1'b1}});
    send_word(REQ_ADD, {MAC_W{1'b1}}, CLS_L, {TAG_W{1'b1}});
    send_word(REQ_LOOKUP, {MAC_W{1'b1}}, CLS_L, '0);
    send_word(REQ_ADD, 48'hFFFF_FFF1_2345, CLS_M, '0);
    send_word(REQ_LOOKUP, 48'hFFFF_FFF0_0000, CLS_M, '0);
    send_word(REQ_ADD, 48'hFFFF_FFFF_F000, CLS_S, 16'h1234);
    send_word(REQ_LOOKUP, 48'hFFFF_FFFF_FABC, CLS_CID, {TAG_W{1'b1}});
    send_word(REQ_LOOKUP, 48'hFFFF_FFE0_0000, CLS_S, '0);
    send_word(REQ_ADD, '0, CLS_L, '0);
    send_word(REQ_LOOKUP, 48'h0000_00AB_CDEF, CLS_L, '0);
    send_word(REQ_ADD, 48'h0000_0012_3456, CLS_L, 16'h5555);
    send_word(REQ_LOOKUP, '0, CLS_M, '0);
    send_word(REQ_ADD, '0, CLS_S, 16'hAAAA);
    send_word(REQ_LOOKUP, 48'h0000_0000_0FFF, CLS_L, '0);
    send_word(REQ_LOOKUP, 48'h0000_0000_1000, CLS_L, '0);
    send_word(REQ_LOOKUP, 48'h5A5A_5A5A_5A5A, CLS_S, 16'h5A5A);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_rate, input int words);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    repeat (words) send_random_word();
  endtask

  // Hold the response side for a long stretch while words keep coming, so the block
  // backs up and stalls its request side.
  task automatic test_response_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = HOLD_OFF;
    repeat (12) send_random_word();
  endtask

  // Pause the request side until every outstanding result is back, then resume.
  task automatic test_drain_pause();
    send_idle_pct = 28;
    stall_pct = 28;
    repeat (8) send_random_word();
    wait_until_drained();
    repeat (8) send_random_word();
  endtask

  // Fill every table to the top, push two more adds into each, then scan deep.
  task automatic test_table_full();
    send_idle_pct = 0;
    stall_pct = 0;
    for (int c = int'(CLS_L); c <= int'(CLS_S); c++) begin
      while (fill[c] < TABLE_ENTRIES)
        send_word(REQ_ADD, random_mac(), 2'(c), TAG_W'($urandom));
      repeat (2) send_word(REQ_ADD, random_mac(), 2'(c), TAG_W'($urandom));
      send_word(REQ_LOOKUP, prefix_mem[c][TABLE_ENTRIES-1], CLS_L, '0);
    end
    send_word(REQ_LOOKUP, random_mac(), CLS_L, '0);
  endtask

  task automatic flag_field(input string field, input longint unsigned want,
      input longint unsigned got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  // Response side: stall at the phase rate, or hold for a requested stretch.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual status %0d",
                 $time, status);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (status !== want.status) flag_field("status", want.status, status);
        if (match_class !== want.mclass) flag_field("match_class", want.mclass, match_class);
        if (found_vendor !== want.vendor) flag_field("found_vendor", want.vendor, found_vendor);
        if (dirty !== want.dirty) flag_field("dirty", want.dirty, dirty);
      end
    end
  end

  // Watchdog: drop the run when no word moves for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
        $display("oui_vendor_prefix_lookup verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(0, 0, 140);
    test_random_traffic(86, 0, 140);
    test_random_traffic(0, 86, 140);
    test_random_traffic(28, 28, 140);
    test_response_backpressure();
    test_drain_pause();
    test_table_full();
    @(negedge clk);
    req_valid <= 1'b0;
    stall_pct = 0;
    wait_until_drained();
    // Keep watching for stray result words.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("oui_vendor_prefix_lookup verification clean");
    end else begin
      $display("oui_vendor_prefix_lookup verification failed");
    end
    $finish;
  end

endmodule
